// File: hdl/f24_pkg.sv
// ============================================================================
// f24_pkg: shared types and constants for the float24 multiply/add/max unit
// Field widths of the 16-bit mantissa / 8-bit exponent format, the width of
// the working mantissa register and the operation codes.
// ============================================================================
package f24_pkg;

	localparam int MAN_W = 16;
	localparam int EXP_W = 8;
	localparam int ACC_W = 2 * MAN_W;
	localparam int KIND_W = 2;
	localparam int CNT_W = 5;
	localparam int ALIGN_MAX = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_MUL = 2'd0,
		KIND_ADD = 2'd1,
		KIND_MAX = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;

	typedef logic signed [MAN_W-1:0] man_t;
	typedef logic signed [EXP_W-1:0] exp_t;
	typedef logic signed [ACC_W-1:0] acc_t;

endpackage

// File: hdl/f24_halve.sv
// ============================================================================
// f24_halve: shared one-step halving unit
// Divides the working mantissa by two, truncating toward zero.
// ============================================================================
module f24_halve (
	input  f24_pkg::acc_t value,
	output f24_pkg::acc_t half
);

	f24_pkg::acc_t biased;

	// bias negative values by one so the arithmetic shift rounds toward zero
	assign biased = value + f24_pkg::acc_t'({{(f24_pkg::ACC_W-1){1'b0}}, value[f24_pkg::ACC_W-1]});
	assign half = biased >>> 1;

endmodule

// File: hdl/float24_multiply_add_max_unit_top.sv
// ============================================================================
// float24_multiply_add_max_unit_top: multiply, add and max on m * 2^e numbers
// One request in flight, the next taken after the result issues; the single
// halving unit does alignment and normalization one bit per cycle. Any output
// stall holds the finished result back before it issues.
// arst_n clears the sequencer and empties the output register.
// ============================================================================
module float24_multiply_add_max_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // a_mantissa[15:0], a_exponent[23:16],
	                               // b_mantissa[39:24], b_exponent[47:40]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // result_mantissa[15:0], result_exponent[23:16]
	output logic        m_tuser    // second_is_max[0]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_ALSET,
		ST_ALIGN,
		ST_PICK,
		ST_DONE
	} state_t;

	state_t state_q;
	f24_pkg::kind_t kind_q;
	f24_pkg::man_t am_q, bm_q, xm_q, ym_q, other_q;
	f24_pkg::exp_t ae_q, be_q, xe_q, ye_q, exp_q;
	f24_pkg::acc_t acc_q;
	logic [f24_pkg::CNT_W-1:0] cnt_q;
	logic negb_q;
	logic sec_q;

	f24_pkg::man_t in_am, in_bm;
	f24_pkg::exp_t in_ae, in_be;
	f24_pkg::kind_t in_kind;
	f24_pkg::acc_t half;
	f24_pkg::acc_t product;
	logic in_fire;
	logic out_free;
	logic norm_big;
	logic x_smaller;
	logic [f24_pkg::EXP_W:0] gap;
	logic [f24_pkg::CNT_W-1:0] gap_cnt;
	logic pick_second;

	assign in_am = f24_pkg::man_t'(s_tdata[15:0]);
	assign in_ae = f24_pkg::exp_t'(s_tdata[23:16]);
	assign in_bm = f24_pkg::man_t'(s_tdata[39:24]);
	assign in_be = f24_pkg::exp_t'(s_tdata[47:40]);
	assign in_kind = f24_pkg::kind_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign product = in_am * in_bm;

	assign norm_big = (acc_q >= f24_pkg::acc_t'(32768)) || (acc_q <= -f24_pkg::acc_t'(32768));

	assign x_smaller = (xe_q < ye_q);
	assign gap = x_smaller ? ({ye_q[7], ye_q} - {xe_q[7], xe_q})
	                       : ({xe_q[7], xe_q} - {ye_q[7], ye_q});
	assign gap_cnt = (gap >= (f24_pkg::EXP_W+1)'(f24_pkg::ALIGN_MAX))
		? f24_pkg::CNT_W'(f24_pkg::ALIGN_MAX) : gap[f24_pkg::CNT_W-1:0];

	assign pick_second = (acc_q < 0) || ((acc_q == 0) && (ae_q < be_q));

	f24_halve u_halve (
		.value(acc_q),
		.half (half)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= f24_pkg::KIND_NOP;
			am_q <= '0;
			bm_q <= '0;
			ae_q <= '0;
			be_q <= '0;
			xm_q <= '0;
			ym_q <= '0;
			xe_q <= '0;
			ye_q <= '0;
			other_q <= '0;
			exp_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			negb_q <= 1'b0;
			sec_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && (state_q != ST_DONE)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						kind_q <= in_kind;
						am_q <= in_am;
						ae_q <= in_ae;
						bm_q <= in_bm;
						be_q <= in_be;
						sec_q <= 1'b0;
						negb_q <= 1'b0;
						unique case (in_kind)
							f24_pkg::KIND_MUL: begin
								acc_q <= product;
								exp_q <= in_ae + in_be;
								state_q <= ST_NORM;
							end
							f24_pkg::KIND_ADD: begin
								xm_q <= in_am;
								xe_q <= in_ae;
								ym_q <= in_bm;
								ye_q <= in_be;
								state_q <= ST_ALSET;
							end
							f24_pkg::KIND_MAX: begin
								acc_q <= -f24_pkg::acc_t'(in_bm);
								exp_q <= in_be;
								xm_q <= in_am;
								xe_q <= in_ae;
								negb_q <= 1'b1;
								state_q <= ST_NORM;
							end
							default: begin
								acc_q <= '0;
								exp_q <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_NORM: begin
					if (norm_big) begin
						acc_q <= half;
						exp_q <= exp_q + f24_pkg::exp_t'(1);
					end else if (negb_q) begin
						ym_q <= acc_q[f24_pkg::MAN_W-1:0];
						ye_q <= exp_q;
						negb_q <= 1'b0;
						state_q <= ST_ALSET;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_ALSET: begin
					// shift the operand with the smaller exponent
					if (x_smaller) begin
						acc_q <= f24_pkg::acc_t'(xm_q);
						other_q <= ym_q;
						exp_q <= ye_q;
					end else begin
						acc_q <= f24_pkg::acc_t'(ym_q);
						other_q <= xm_q;
						exp_q <= xe_q;
					end
					cnt_q <= gap_cnt;
					state_q <= ST_ALIGN;
				end
				ST_ALIGN: begin
					if (cnt_q != '0) begin
						acc_q <= half;
						cnt_q <= cnt_q - f24_pkg::CNT_W'(1);
					end else begin
						acc_q <= acc_q + f24_pkg::acc_t'(other_q);
						state_q <= (kind_q == f24_pkg::KIND_MAX) ? ST_PICK : ST_NORM;
					end
				end
				ST_PICK: begin
					sec_q <= pick_second;
					acc_q <= f24_pkg::acc_t'(pick_second ? bm_q : am_q);
					exp_q <= pick_second ? be_q : ae_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata <= {exp_q, acc_q[f24_pkg::MAN_W-1:0]};
						m_tuser <= sec_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/f24_checker.sv
// ============================================================================
// f24_checker: port-level checks for the float24 multiply/add/max unit
// Watches the request and result handshakes of the top level over time.
// ============================================================================
module f24_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while a request is in flight");

	a_ready_falls_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("ready dropped without an accepted request");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared one cycle after request");

	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result issued while sequencer still busy");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind float24_multiply_add_max_unit_top f24_checker u_f24_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// File: dv/float24_multiply_add_max_unit_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// float24_multiply_add_max_unit_checker: result predictor and scoreboard
// Watches both stream channels of the float24 unit. For each accepted request
// it computes the multiply, add or max outcome at the block's field widths and
// queues it. Each accepted result is compared field by field against the
// oldest queued outcome. Reports failures and outstanding results to the bench.
// ============================================================================
module float24_multiply_add_max_unit_checker
	import f24_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // a_mantissa[15:0], a_exponent[23:16],
	                               // b_mantissa[39:24], b_exponent[47:40]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // result_mantissa[15:0], result_exponent[23:16]
	input  logic        m_tuser,   // second_is_max[0]
	output int          fail_count,
	output int          outstanding,
	output int          results_checked
);

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		man_t man;
		exp_t ex;
	} num_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		num_t              a;
		num_t              b;
		num_t              res;
		logic              second_max;
	} outcome_t;

	outcome_t expected_results[$];

	function automatic num_t renormalize(input int m, input int e);
		int   steps;
		num_t r;
		steps = 0;
		while (m >= 32768 || m <= -32768) begin
			m = m / 2;
			steps++;
		end
		r.man = man_t'(m);
		r.ex = exp_t'(int'(exp_t'(e)) + steps);
		return r;
	endfunction

	function automatic num_t product(input num_t x, input num_t y);
		return renormalize(int'(x.man) * int'(y.man), int'(x.ex) + int'(y.ex));
	endfunction

	function automatic int shift_down(input int m, input int s);
		if (s >= ALIGN_MAX)
			return 0;
		return m / (1 << s);
	endfunction

	function automatic num_t add_aligned(input num_t x, input num_t y);
		int c;
		c = (x.ex > y.ex) ? int'(x.ex) : int'(y.ex);
		return renormalize(shift_down(int'(x.man), c - int'(x.ex)) +
			shift_down(int'(y.man), c - int'(y.ex)), c);
	endfunction

	function automatic outcome_t predict_result(input logic [KIND_W-1:0] k,
		input num_t a, input num_t b);
		outcome_t o;
		num_t     minus_one;
		num_t     diff;
		o.kind = k;
		o.a = a;
		o.b = b;
		o.res.man = '0;
		o.res.ex = '0;
		o.second_max = 1'b0;
		case (kind_t'(k))
			KIND_MUL: o.res = product(a, b);
			KIND_ADD: o.res = add_aligned(a, b);
			KIND_MAX: begin
				minus_one.man = -1;
				minus_one.ex = 0;
				diff = add_aligned(a, product(b, minus_one));
				if (diff.man < 0)
					o.second_max = 1'b1;
				else if (diff.man > 0)
					o.second_max = 1'b0;
				else
					o.second_max = (a.ex < b.ex);
				o.res = o.second_max ? b : a;
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk) begin
		num_t     a;
		num_t     b;
		outcome_t want;
		man_t     got_man;
		exp_t     got_ex;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				a.man = s_tdata[15:0];
				a.ex = s_tdata[23:16];
				b.man = s_tdata[39:24];
				b.ex = s_tdata[47:40];
				expected_results.push_back(predict_result(s_tuser, a, b));
			end
			if (m_tvalid && m_tready) begin
				got_man = m_tdata[15:0];
				got_ex = m_tdata[23:16];
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: unexpected result (%0d, %0d, %0b)", $realtime,
							got_man, got_ex, m_tuser);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (got_man !== want.res.man || got_ex !== want.res.ex ||
						m_tuser !== want.second_max) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: mismatch kind %0d a=(%0d,%0d) b=(%0d,%0d) expected (%0d,%0d,%0b) got (%0d,%0d,%0b)",
								$realtime, want.kind, want.a.man, want.a.ex, want.b.man,
								want.b.ex, want.res.man, want.res.ex, want.second_max,
								got_man, got_ex, m_tuser);
					end
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// File: dv/float24_multiply_add_max_unit_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// float24_multiply_add_max_unit_top_test: stimulus and verdict for the unit
// Drives directed corner requests then about a thousand random multiply, add,
// max and unused-kind requests with random gaps and output stalls, including
// a long output hold-off and a full drain pause. The checker does the scoring.
// ============================================================================
module float24_multiply_add_max_unit_top_test;
	import f24_pkg::*;

	localparam int RANDOM_REQUESTS  = 1080;
	localparam int QUIET_REQUESTS   = 150;
	localparam int SINK_HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES     = 40;
	localparam int TIMEOUT_NS       = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // a_mantissa[15:0], a_exponent[23:16],
	                        // b_mantissa[39:24], b_exponent[47:40]
	logic [1:0]  s_tuser;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // result_mantissa[15:0], result_exponent[23:16]
	logic        m_tuser;   // second_is_max[0]

	int fail_count;
	int outstanding;
	int results_checked;
	int kind_count [4];
	int send_gap_pct;
	bit quiet;
	bit sink_hold_req;
	bit sink_hold_seen;

	float24_multiply_add_max_unit_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	float24_multiply_add_max_unit_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_request(input kind_t k, input man_t am, input exp_t ae,
		input man_t bm, input exp_t be);
		if (!quiet && $urandom_range(1, 100) <= send_gap_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = k;
		s_tdata = {be, bm, ae, am};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		kind_count[k]++;
	endtask

	task automatic wait_drained();
		while (outstanding != 0) @(negedge clk);
	endtask

	function automatic man_t random_mantissa();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			case ($urandom_range(0, 5))
				0: return -32768;
				1: return 32767;
				2: return 0;
				3: return 1;
				4: return -1;
				default: return -32767;
			endcase
		end
		if (pick <= 2)
			return man_t'(int'($urandom_range(0, 512)) - 256);
		return man_t'($urandom);
	endfunction

	function automatic exp_t random_exponent();
		if ($urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 3))
				0: return -128;
				1: return 127;
				2: return 0;
				default: return -1;
			endcase
		end
		return exp_t'($urandom);
	endfunction

	task automatic send_random_request();
		kind_t k;
		man_t  am;
		man_t  bm;
		exp_t  ae;
		exp_t  be;
		int    pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			k = KIND_NOP;
		else if (pick <= 5)
			k = KIND_MUL;
		else if (pick <= 10)
			k = KIND_ADD;
		else
			k = KIND_MAX;
		am = random_mantissa();
		bm = random_mantissa();
		ae = random_exponent();
		if ($urandom_range(0, 3) == 0)
			be = random_exponent();
		else
			be = exp_t'(int'(ae) + int'($urandom_range(0, 40)) - 20);
		if (k == KIND_MAX && $urandom_range(0, 5) == 0) begin
			bm = am;
			if ($urandom_range(0, 1) == 1)
				be = ae;
		end
		send_request(k, am, ae, bm, be);
	endtask

	initial begin
		m_tready = 1'b0;
		sink_hold_seen = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			int stall_pct;
			int mode_left;
			if (mode_left == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 45;
				endcase
				mode_left = 64;
			end
			mode_left--;
			if (sink_hold_req != sink_hold_seen) begin
				sink_hold_seen = sink_hold_req;
				m_tready = 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
			end else if (!quiet && $urandom_range(1, 100) <= stall_pct) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_MUL;
		sink_hold_req = 1'b0;
		quiet = 1'b0;
		send_gap_pct = 20;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(KIND_MUL, 32767, 0, 32767, 0);
		send_request(KIND_MUL, -32768, 0, -32768, 0);
		send_request(KIND_MUL, -32768, 0, 1, 0);
		send_request(KIND_MUL, 32767, 0, 1, 0);
		send_request(KIND_MUL, 3, 127, 5, 127);
		send_request(KIND_MUL, -7, -128, 9, -128);
		send_request(KIND_MUL, -32768, 127, 1, 0);
		send_request(KIND_MUL, 0, 55, -32768, -3);
		send_request(KIND_ADD, 32767, 0, 32767, 0);
		send_request(KIND_ADD, -32768, 0, -32768, 0);
		send_request(KIND_ADD, 32767, 127, -32768, -128);
		send_request(KIND_ADD, 1000, 20, -32768, 5);
		send_request(KIND_ADD, 1000, 20, -32768, 4);
		send_request(KIND_ADD, -3, 0, 5, 1);
		send_request(KIND_ADD, 32767, 127, 32767, 127);
		send_request(KIND_MAX, 1234, 7, 1234, 7);
		send_request(KIND_MAX, 0, 3, 0, 5);
		send_request(KIND_MAX, 0, 5, 0, 3);
		send_request(KIND_MAX, 100, -128, -32768, 127);
		send_request(KIND_MAX, 500, 2, 400, 2);
		send_request(KIND_MAX, -500, 2, 400, -1);
		send_request(KIND_MAX, 32767, -128, -32768, -128);
		send_request(KIND_NOP, 16'h5A5A, 8'h7F, 16'hA5A5, 8'h80);
		send_request(KIND_NOP, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
		wait_drained();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: send_gap_pct = 0;
					1: send_gap_pct = 10;
					default: send_gap_pct = 40;
				endcase
			end
			if (n == RANDOM_REQUESTS - QUIET_REQUESTS)
				quiet = 1'b1;
			if (n == 250 || n == 700)
				sink_hold_req = ~sink_hold_req;
			if (n == 150 || n == 550)
				wait_drained();
			send_random_request();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d multiply, %0d add, %0d max and %0d unused-kind requests; %0d results checked.",
			kind_count[KIND_MUL], kind_count[KIND_ADD], kind_count[KIND_MAX],
			kind_count[KIND_NOP], results_checked);
		$display("Operands mixed range extremes, small values and nearby exponents, with gaps and output stalls.");
		if (fail_count == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: float24_multiply_add_max_unit_top.f
hdl/f24_pkg.sv
hdl/f24_halve.sv
hdl/float24_multiply_add_max_unit_top.sv
hdl/f24_checker.sv
dv/float24_multiply_add_max_unit_checker.sv
dv/float24_multiply_add_max_unit_top_test.sv
